// ===== src/thc_pkg.sv =====
// shared types and constants for the temperature/humidity compensation block
package thc_pkg;

    localparam int unsigned RawTempW  = 20;
    localparam int unsigned RawHumW   = 16;
    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 48;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = 2;
    localparam int unsigned PipeStages = 13;

    localparam logic [CfgIdxW-1:0] RegTempCal = 3'd0;
    localparam logic [CfgIdxW-1:0] RegHumH1   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegHumH2   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegHumH3   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegHumH4   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegHumH5   = 3'd5;
    localparam logic [CfgIdxW-1:0] RegHumH6   = 3'd6;

    localparam logic signed [31:0] HumOffset  = 32'sd76800;
    localparam logic signed [31:0] HumRound15 = 32'sd16384;
    localparam logic signed [31:0] HumC32768  = 32'sd32768;
    localparam logic signed [31:0] HumC2M     = 32'sd2097152;
    localparam logic signed [31:0] HumRound14 = 32'sd8192;
    localparam logic signed [31:0] HumMax     = 32'sd419430400;
    localparam logic signed [31:0] TempRound  = 32'sd128;

    typedef struct packed {
        logic [RawTempW-1:0] raw_temp;
        logic [RawHumW-1:0]  raw_hum;
    } t_sample;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [7:0]         h1;
        logic signed [15:0] h2;
        logic [7:0]         h3;
        logic signed [15:0] h4;
        logic signed [15:0] h5;
        logic signed [7:0]  h6;
    } t_coef;

    // low 32 bits of a signed product
    function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

endpackage

// ===== src/temp_humidity_compensation_core.sv =====
// top level: register file, input queue and compensation pipeline
//
// usage:
//   raise start with i_raw_temp/i_raw_hum while busy is low; the word is
//   taken at that edge. busy rises only when the input queue is full, which
//   never happens since the datapath drains one word every cycle.
//   one word per cycle is sustained.
//   results come out on o_fine_temp, o_temp_centi, o_hum_q10 with o_valid
//   high for exactly one cycle, once the word has passed the input queue
//   and then the 13 stages of the multiplier chain.
//   results cannot be held off: the receiver must take them when shown.
//   calibration registers are written through i_cfg_valid/o_cfg_ready with
//   i_cfg_index and i_cfg_data; write them only while no word is in flight.
//   index 0 holds T1/T2/T3 packed, 1..6 hold H1..H6; other indexes ignored.
//   reset (synchronous, active low) clears registers, queue and valid pipe.
module temp_humidity_compensation_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [thc_pkg::RawTempW-1:0] i_raw_temp,
    input  logic [thc_pkg::RawHumW-1:0]  i_raw_hum,
    output logic                         o_valid,
    output logic signed [31:0]           o_fine_temp,
    output logic signed [23:0]           o_temp_centi,
    output logic [16:0]                  o_hum_q10,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [thc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [thc_pkg::CfgDataW-1:0] i_cfg_data
);
    import thc_pkg::*;

    t_coef   r_coef;
    t_sample s_in, s_head;
    logic    s_full, s_empty, s_push, s_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegTempCal: begin
                    r_coef.t1 <= i_cfg_data[15:0];
                    r_coef.t2 <= i_cfg_data[31:16];
                    r_coef.t3 <= i_cfg_data[47:32];
                end
                RegHumH1: r_coef.h1 <= i_cfg_data[7:0];
                RegHumH2: r_coef.h2 <= i_cfg_data[15:0];
                RegHumH3: r_coef.h3 <= i_cfg_data[7:0];
                RegHumH4: r_coef.h4 <= i_cfg_data[15:0];
                RegHumH5: r_coef.h5 <= i_cfg_data[15:0];
                RegHumH6: r_coef.h6 <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign busy   = s_full;
    assign s_push = start && !s_full;
    assign s_pop  = !s_empty;
    assign s_in   = '{raw_temp: i_raw_temp, raw_hum: i_raw_hum};

    thc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_sample(s_in),
        .i_pop   (s_pop),
        .o_full  (s_full),
        .o_empty (s_empty),
        .o_head  (s_head)
    );

    thc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_pop),
        .i_sample    (s_head),
        .i_coef      (r_coef),
        .o_valid     (o_valid),
        .o_fine_temp (o_fine_temp),
        .o_temp_centi(o_temp_centi),
        .o_hum_q10   (o_hum_q10)
    );
endmodule

// ===== src/thc_front.sv =====
// input side: takes commands and queues raw samples for the datapath
module thc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  thc_pkg::t_sample   i_sample,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output thc_pkg::t_sample   o_head
);
    import thc_pkg::*;

    t_sample                r_mem [QueueDepth];
    logic [QueuePtrW-1:0]   r_wp, r_rp, n_wp, n_rp;
    logic [QueuePtrW:0]     r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp + QueuePtrW'(i_push);
        n_rp  = r_rp + QueuePtrW'(i_pop);
        n_cnt = r_cnt + (QueuePtrW+1)'(i_push) - (QueuePtrW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_sample;
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QueuePtrW+1)'(QueueDepth));
endmodule

// ===== src/thc_back.sv =====
// compensation datapath: pipelined multiplier chain
module thc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  thc_pkg::t_sample    i_sample,
    input  thc_pkg::t_coef      i_coef,
    output logic                o_valid,
    output logic signed [31:0]  o_fine_temp,
    output logic signed [23:0]  o_temp_centi,
    output logic [16:0]         o_hum_q10
);
    import thc_pkg::*;

    logic [PipeStages-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[PipeStages-2:0], i_valid};
    end

    // stage 1: differences
    logic signed [31:0] r1_d1, r1_d2, r1_hum;
    always_ff @(posedge i_clk) begin
        r1_d1  <= 32'(signed'({1'b0, i_sample.raw_temp} >> 3))
                  - 32'(signed'({15'd0, i_coef.t1, 1'b0}));
        r1_d2  <= 32'(signed'({1'b0, i_sample.raw_temp} >> 4))
                  - 32'(signed'({16'd0, i_coef.t1}));
        r1_hum <= 32'(signed'({1'b0, i_sample.raw_hum}));
    end

    // stage 2: d1*t2, d2*d2
    logic signed [31:0] r2_v1, r2_sq, r2_hum;
    always_ff @(posedge i_clk) begin
        r2_v1  <= mul32(r1_d1, 32'(i_coef.t2)) >>> 11;
        r2_sq  <= mul32(r1_d2, r1_d2) >>> 12;
        r2_hum <= r1_hum;
    end

    // stage 3: var2 and fine temperature
    logic signed [31:0] r3_tf, r3_hum;
    always_ff @(posedge i_clk) begin
        r3_tf  <= r2_v1 + (mul32(r2_sq, 32'(i_coef.t3)) >>> 14);
        r3_hum <= r2_hum;
    end

    // stage 4: centi, v, humidity base
    logic signed [31:0] r4_tf, r4_v, r4_a;
    logic signed [23:0] r4_tc;
    logic signed [31:0] s4_t5;
    always_comb s4_t5 = mul32(r3_tf, 32'sd5) + TempRound;
    always_ff @(posedge i_clk) begin
        r4_tf <= r3_tf;
        r4_tc <= 24'(s4_t5 >>> 8);
        r4_v  <= r3_tf - HumOffset;
        r4_a  <= (r3_hum <<< 14) - (32'(i_coef.h4) <<< 20);
    end

    // stage 5: h5*v, v*h6, v*h3
    logic signed [31:0] r5_tf, r5_a, r5_b, r5_c;
    logic signed [23:0] r5_tc;
    always_ff @(posedge i_clk) begin
        r5_tf <= r4_tf;
        r5_tc <= r4_tc;
        r5_a  <= (r4_a - mul32(32'(i_coef.h5), r4_v) + HumRound15) >>> 15;
        r5_b  <= mul32(r4_v, 32'(i_coef.h6)) >>> 10;
        r5_c  <= (mul32(r4_v, 32'(signed'({24'd0, i_coef.h3}))) >>> 11) + HumC32768;
    end

    // stage 6: b*c
    logic signed [31:0] r6_tf, r6_a, r6_e;
    logic signed [23:0] r6_tc;
    always_ff @(posedge i_clk) begin
        r6_tf <= r5_tf;
        r6_tc <= r5_tc;
        r6_a  <= r5_a;
        r6_e  <= (mul32(r5_b, r5_c) >>> 10) + HumC2M;
    end

    // stage 7: e*h2
    logic signed [31:0] r7_tf, r7_a, r7_e;
    logic signed [23:0] r7_tc;
    always_ff @(posedge i_clk) begin
        r7_tf <= r6_tf;
        r7_tc <= r6_tc;
        r7_a  <= r6_a;
        r7_e  <= (mul32(r6_e, 32'(i_coef.h2)) + HumRound14) >>> 14;
    end

    // stage 8: a*e
    logic signed [31:0] r8_tf, r8_v;
    logic signed [23:0] r8_tc;
    always_ff @(posedge i_clk) begin
        r8_tf <= r7_tf;
        r8_tc <= r7_tc;
        r8_v  <= mul32(r7_a, r7_e);
    end

    // stage 9: square of v>>15
    logic signed [31:0] r9_tf, r9_v, r9_sq;
    logic signed [23:0] r9_tc;
    always_ff @(posedge i_clk) begin
        r9_tf <= r8_tf;
        r9_tc <= r8_tc;
        r9_v  <= r8_v;
        r9_sq <= mul32(r8_v >>> 15, r8_v >>> 15) >>> 7;
    end

    // stage 10: times h1
    logic signed [31:0] r10_tf, r10_v, r10_p;
    logic signed [23:0] r10_tc;
    always_ff @(posedge i_clk) begin
        r10_tf <= r9_tf;
        r10_tc <= r9_tc;
        r10_v  <= r9_v;
        r10_p  <= mul32(r9_sq, 32'(signed'({24'd0, i_coef.h1}))) >>> 4;
    end

    // stage 11: subtract
    logic signed [31:0] r11_tf, r11_v;
    logic signed [23:0] r11_tc;
    always_ff @(posedge i_clk) begin
        r11_tf <= r10_tf;
        r11_tc <= r10_tc;
        r11_v  <= r10_v - r10_p;
    end

    // stage 12: clamp
    logic signed [31:0] r12_tf;
    logic signed [23:0] r12_tc;
    logic [16:0]        r12_h;
    always_ff @(posedge i_clk) begin
        r12_tf <= r11_tf;
        r12_tc <= r11_tc;
        if (r11_v < 0)            r12_h <= '0;
        else if (r11_v > HumMax)  r12_h <= 17'(HumMax >>> 12);
        else                      r12_h <= 17'(r11_v >>> 12);
    end

    // stage 13: output register
    logic signed [31:0] r13_tf;
    logic signed [23:0] r13_tc;
    logic [16:0]        r13_h;
    always_ff @(posedge i_clk) begin
        r13_tf <= r12_tf;
        r13_tc <= r12_tc;
        r13_h  <= r12_h;
    end

    assign o_valid      = r_vld[PipeStages-1];
    assign o_fine_temp  = r13_tf;
    assign o_temp_centi = r13_tc;
    assign o_hum_q10    = r13_h;
endmodule

// ===== src/thc_checker.sv =====
// port-level checker for the compensation core, bound to the top level
module thc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [16:0] o_hum_q10,
    input logic        o_cfg_ready
);
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hum_q10 <= 17'd102400) else $error("humidity out of range");
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("queue filled");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##14 o_valid) else $error("result missing");
    a_no_spurious: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result after reset");
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready) else $error("config not ready");
endmodule

bind temp_humidity_compensation_core thc_checker u_thc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_hum_q10  (o_hum_q10),
    .o_cfg_ready(o_cfg_ready)
);

// ===== dv/tb.sv =====
// self-checking testbench for the temperature/humidity compensation core
`timescale 1ns / 100ps

module tb;
    import thc_pkg::*;

    // index past the last register, writes to it are dropped
    localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

    typedef struct {
        logic signed [31:0] fine;
        logic signed [23:0] centi;
        logic [16:0]        hum;
    } t_reading;

    class comp_scoreboard;
        t_coef    coef = '0;
        t_reading pending[$];
        int       errors;
        int       checked;

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                RegTempCal: begin
                    coef.t1 = val[15:0];
                    coef.t2 = val[31:16];
                    coef.t3 = val[47:32];
                end
                RegHumH1: coef.h1 = val[7:0];
                RegHumH2: coef.h2 = val[15:0];
                RegHumH3: coef.h3 = val[7:0];
                RegHumH4: coef.h4 = val[15:0];
                RegHumH5: coef.h5 = val[15:0];
                RegHumH6: coef.h6 = val[7:0];
                default: ;
            endcase
        endfunction

        // note an accepted raw sample and queue the compensated reading
        function void note_sample(logic [RawTempW-1:0] rt, logic [RawHumW-1:0] rh);
            logic signed [63:0] p;
            logic signed [31:0] d, v1, v2, tf, v, a, b, c, e, t1, adc_t, adc_h;
            t_reading r;
            t1 = {16'd0, coef.t1};
            adc_t = {12'd0, rt};
            adc_h = {16'd0, rh};
            d = (adc_t >>> 3) - (t1 <<< 1);
            p = d * 32'(coef.t2);      v1 = $signed(p[31:0]) >>> 11;
            d = (adc_t >>> 4) - t1;
            p = d * d;                 v2 = $signed(p[31:0]) >>> 12;
            p = v2 * 32'(coef.t3);     v2 = $signed(p[31:0]) >>> 14;
            tf = v1 + v2;
            p = tf * 5;                r.centi = 24'(($signed(p[31:0]) + TempRound) >>> 8);
            r.fine = tf;
            v = tf - HumOffset;
            p = 32'(coef.h4) * 1048576;
            a = (adc_h <<< 14) - p[31:0];
            p = 32'(coef.h5) * v;      a = a - p[31:0];
            a = (a + HumRound15) >>> 15;
            p = v * 32'(coef.h6);      b = $signed(p[31:0]) >>> 10;
            p = v * {24'd0, coef.h3};  c = ($signed(p[31:0]) >>> 11) + HumC32768;
            p = b * c;                 e = ($signed(p[31:0]) >>> 10) + HumC2M;
            p = e * 32'(coef.h2);      e = ($signed(p[31:0]) + HumRound14) >>> 14;
            p = a * e;                 v = p[31:0];
            a = v >>> 15;
            p = a * a;                 a = $signed(p[31:0]) >>> 7;
            p = a * {24'd0, coef.h1};  a = $signed(p[31:0]) >>> 4;
            v = v - a;
            if (v < 0) v = 0;
            if (v > HumMax) v = HumMax;
            r.hum = 17'(v >>> 12);
            pending.push_back(r);
        endfunction

        function void check_reading(logic signed [31:0] f, logic signed [23:0] tc,
                                    logic [16:0] h);
            t_reading x;
            if (pending.size() == 0) begin
                $error("unexpected reading fine=%0d", f);
                errors++;
                return;
            end
            x = pending.pop_front();
            checked++;
            if (f !== x.fine) begin
                $error("fine_temp exp %0d got %0d", x.fine, f); errors++;
            end
            if (tc !== x.centi) begin
                $error("temp_centi exp %0d got %0d", x.centi, tc); errors++;
            end
            if (h !== x.hum) begin
                $error("hum_q10 exp %0d got %0d", x.hum, h); errors++;
            end
        endfunction
    endclass

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                start = 0;
    logic                busy;
    logic [RawTempW-1:0] i_raw_temp = 0;
    logic [RawHumW-1:0]  i_raw_hum = 0;
    logic                o_valid;
    logic signed [31:0]  o_fine_temp;
    logic signed [23:0]  o_temp_centi;
    logic [16:0]         o_hum_q10;
    logic                i_cfg_valid = 0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = 0;
    logic [CfgDataW-1:0] i_cfg_data = 0;

    comp_scoreboard sb = new();
    int samples_sent;
    int cfg_writes;

    temp_humidity_compensation_core uut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_reading(o_fine_temp, o_temp_centi, o_hum_q10);
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // valid is left high so writes can follow back to back; load_cal drops it
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic send_sample(logic [RawTempW-1:0] rt, logic [RawHumW-1:0] rh,
                               bit idle_ok);
        int g;
        g = idle_ok ? gap_len() : 0;
        if (g > 0) begin
            start <= 0;
            repeat (g) @(posedge i_clk);
        end
        start      <= 1;
        i_raw_temp <= rt;
        i_raw_hum  <= rh;
        do @(posedge i_clk); while (busy);
        sb.note_sample(rt, rh);
        samples_sent++;
    endtask

    task automatic drain();
        int n;
        start <= 0;
        n = 0;
        while (sb.pending.size() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    // typical calibration set, or random / extreme values
    task automatic load_cal(int mode);
        logic [CfgDataW-1:0] tc;
        case (mode)
            0: tc = {16'd50, 16'd26435, 16'd27504};
            1: tc = '1;
            2: tc = {16'h8000, 16'h8000, 16'h0000};
            default: tc = CfgDataW'({$urandom(), $urandom()});
        endcase
        write_reg(RegTempCal, tc);
        if (mode == 0) begin
            write_reg(RegHumH1, CfgDataW'(75));
            write_reg(RegHumH2, CfgDataW'(362));
            write_reg(RegHumH3, CfgDataW'(0));
            write_reg(RegHumH4, CfgDataW'(310));
            write_reg(RegHumH5, CfgDataW'(50));
            write_reg(RegHumH6, CfgDataW'(30));
        end else if (mode == 1) begin
            for (int k = 1; k <= 6; k++) write_reg(k[CfgIdxW-1:0], '1);
        end else if (mode == 2) begin
            write_reg(RegHumH1, CfgDataW'(0));
            write_reg(RegHumH2, CfgDataW'(16'h8000));
            write_reg(RegHumH3, CfgDataW'(8'hff));
            write_reg(RegHumH4, CfgDataW'(16'h7fff));
            write_reg(RegHumH5, CfgDataW'(16'h8000));
            write_reg(RegHumH6, CfgDataW'(8'h80));
        end else begin
            for (int k = 1; k <= 6; k++)
                write_reg(k[CfgIdxW-1:0], CfgDataW'({$urandom(), $urandom()}));
        end
        write_reg(RegUnused, CfgDataW'({$urandom(), $urandom()}));
        i_cfg_valid <= 0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // coefficients all zero after reset
        send_sample('1, '1, 1'b0);
        send_sample(20'd0, 16'd0, 1'b0);
        drain();

        load_cal(0);
        send_sample(20'd519888, 16'd30000, 1'b0);
        send_sample(20'd0, 16'd0, 1'b0);
        send_sample('1, '1, 1'b0);
        send_sample(20'h80000, 16'h8000, 1'b0);
        send_sample(20'h7ffff, 16'h7fff, 1'b0);
        send_sample(20'd400000, 16'd0, 1'b0);
        send_sample(20'd600000, 16'hffff, 1'b0);
        drain();
        load_cal(1);
        send_sample(20'd0, 16'd0, 1'b0);
        send_sample('1, '1, 1'b0);
        send_sample(20'd519888, 16'd30000, 1'b0);
        drain();
        load_cal(2);
        send_sample(20'd0, 16'd0, 1'b0);
        send_sample('1, '1, 1'b0);
        send_sample(20'd519888, 16'd30000, 1'b0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            load_cal(ph % 2 == 0 ? 0 : 3);
            for (int i = 0; i < 200; i++) begin
                if (ph % 2 == 0)
                    send_sample(RawTempW'($urandom_range(350000, 650000)),
                                RawHumW'($urandom()), 1'b1);
                else
                    send_sample(RawTempW'($urandom()), RawHumW'($urandom()), i > 100);
            end
            drain();
        end

        $display("sent %0d samples over %0d register writes, %0d readings checked",
                 samples_sent, cfg_writes, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
